// ===== sv/gds_pkg.sv =====
// Shared types and constants of the gas diffusion grid step core.
// Used by gds_stencil and gas_diffusion_grid_step_core; no dependencies.
`default_nettype none
package gds_pkg;

   typedef struct packed {
      logic [2:0]        kind;
      logic signed [7:0] col;
      logic signed [7:0] row;
      logic [31:0]       amount;
   } req_type;

   typedef struct packed {
      logic [31:0] pressure;
      logic        wall;
      logic        in_range;
      logic        saturated;
   } rsp_type;

   // One grid cell as it is kept in memory.
   typedef struct packed {
      logic        wall;
      logic [31:0] pressure;
   } cell_word_type;

   // One tap of the sweep window: the cell and its precomputed fifth.
   typedef struct packed {
      logic        wall;
      logic [31:0] pressure;
      logic [29:0] share;
   } tap_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CMD,
      ST_STEP
   } state_type;

   localparam logic [2:0] KIND_ADD_WALL  = 3'd0;
   localparam logic [2:0] KIND_DEL_WALL  = 3'd1;
   localparam logic [2:0] KIND_ADD_PRESS = 3'd2;
   localparam logic [2:0] KIND_SUB_PRESS = 3'd3;
   localparam logic [2:0] KIND_STEP      = 3'd4;
   localparam logic [2:0] KIND_READ      = 3'd5;
   localparam logic [2:0] KIND_CLEAR     = 3'd6;
   localparam logic [2:0] KIND_UNUSED    = 3'd7;

   // floor(x / 5) == (x * RECIP_FIFTH) >> 34 for every 32-bit x.
   localparam logic [31:0] RECIP_FIFTH = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 34;

   localparam logic [31:0] PRESSURE_MAX = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ===== sv/gds_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none
module gds_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/gds_stencil.sv =====
// Sweep datapath of a diffusion step: fifth divider, row window and merge.
// Depends on gds_pkg.
`default_nettype none
module gds_stencil #(
   parameter int GRID_SIZE = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 sweep_start,
   input  wire logic                                 in_valid,
   input  wire logic                                 in_pad,
   input  wire gds_pkg::cell_word_type               in_word,
   output logic                                      out_valid,
   output logic                                      out_last,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]    out_addr,
   output gds_pkg::cell_word_type                    out_word
);

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_SIZE);
   localparam int SCW   = $clog2(CELLS + GRID_SIZE + 1);
   localparam int TAPS  = 2 * GRID_SIZE + 1;

   // Divider stage.
   logic                   m_v_ff;
   gds_pkg::cell_word_type m_word_ff;
   logic [63:0]            m_prod_ff;
   gds_pkg::cell_word_type m_word_in;
   logic [63:0]            m_prod_in;

   // Window: tap 0 holds the newest cell, the center tap sits one row back.
   gds_pkg::tap_type win_ff [TAPS];
   gds_pkg::tap_type new_tap;
   logic [SCW-1:0]   shcnt_ff;
   logic             a_v_ff;
   logic [CW-1:0]    cx_ff;
   logic [CW-1:0]    cy_ff;
   logic [AW-1:0]    caddr_ff;

   // Gather stage.
   logic        b_v_ff;
   logic        b_last_ff;
   logic [AW-1:0] b_addr_ff;
   logic        b_wall_ff;
   logic [31:0] b_p_ff;
   logic [31:0] b_loss_ff;
   logic [31:0] b_inc_ff;

   // Merge stage.
   logic                   w_v_ff;
   logic                   w_last_ff;
   logic [AW-1:0]          w_addr_ff;
   gds_pkg::cell_word_type w_word_ff;

   gds_pkg::tap_type c_tap, l_tap, r_tap, u_tap, d_tap;
   logic        hl, hr, hu, hd;
   logic [2:0]  give_cnt;
   logic [31:0] loss;
   logic [31:0] inc;
   logic [32:0] merged;

   always_comb begin
      m_word_in = in_pad ? '0 : in_word;
      m_prod_in = 64'(m_word_in.pressure) * 64'(gds_pkg::RECIP_FIFTH);
      new_tap.wall     = m_word_ff.wall;
      new_tap.pressure = m_word_ff.pressure;
      new_tap.share    = m_prod_ff[gds_pkg::RECIP_SHIFT +: 30];
   end

   always_comb begin
      c_tap = win_ff[GRID_SIZE];
      l_tap = win_ff[GRID_SIZE+1];
      r_tap = win_ff[GRID_SIZE-1];
      u_tap = win_ff[2*GRID_SIZE];
      d_tap = win_ff[0];
      hl = (cx_ff != '0);
      hr = (cx_ff != CW'(GRID_SIZE - 1));
      hu = (cy_ff != '0);
      hd = (cy_ff != CW'(GRID_SIZE - 1));
      give_cnt = 3'(hl && !l_tap.wall) + 3'(hr && !r_tap.wall)
               + 3'(hu && !u_tap.wall) + 3'(hd && !d_tap.wall);
      case (give_cnt)
         3'd0:    loss = '0;
         3'd1:    loss = {2'b00, c_tap.share};
         3'd2:    loss = {1'b0, c_tap.share, 1'b0};
         3'd3:    loss = {1'b0, c_tap.share, 1'b0} + {2'b00, c_tap.share};
         3'd4:    loss = {c_tap.share, 2'b00};
         default: loss = '0;
      endcase
      // A wall cell still gives but never receives.
      if (c_tap.wall) begin
         inc = '0;
      end else begin
         inc = (hl ? {2'b00, l_tap.share} : 32'd0) + (hr ? {2'b00, r_tap.share} : 32'd0)
             + (hu ? {2'b00, u_tap.share} : 32'd0) + (hd ? {2'b00, d_tap.share} : 32'd0);
      end
      merged = {1'b0, b_p_ff} - {1'b0, b_loss_ff} + {1'b0, b_inc_ff};
   end

   always_ff @(posedge clock) begin
      m_word_ff <= m_word_in;
      m_prod_ff <= m_prod_in;
      if (m_v_ff) begin
         win_ff[0] <= new_tap;
         for (int i = 1; i < TAPS; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
      b_addr_ff <= caddr_ff;
      b_last_ff <= (caddr_ff == AW'(CELLS - 1));
      b_wall_ff <= c_tap.wall;
      b_p_ff    <= c_tap.pressure;
      b_loss_ff <= loss;
      b_inc_ff  <= inc;
      w_addr_ff <= b_addr_ff;
      w_last_ff <= b_last_ff;
      w_word_ff.wall     <= b_wall_ff;
      w_word_ff.pressure <= merged[32] ? gds_pkg::PRESSURE_MAX : merged[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff   <= 1'b0;
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         w_v_ff   <= 1'b0;
         shcnt_ff <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         caddr_ff <= '0;
      end else begin
         m_v_ff <= in_valid;
         a_v_ff <= m_v_ff && (shcnt_ff >= SCW'(GRID_SIZE));
         b_v_ff <= a_v_ff;
         w_v_ff <= b_v_ff;
         if (sweep_start) begin
            shcnt_ff <= '0;
            cx_ff    <= '0;
            cy_ff    <= '0;
            caddr_ff <= '0;
         end else begin
            if (m_v_ff) begin
               shcnt_ff <= shcnt_ff + 1'b1;
            end
            if (a_v_ff) begin
               caddr_ff <= caddr_ff + 1'b1;
               if (cx_ff == CW'(GRID_SIZE - 1)) begin
                  cx_ff <= '0;
                  cy_ff <= cy_ff + 1'b1;
               end else begin
                  cx_ff <= cx_ff + 1'b1;
               end
            end
         end
      end
   end

   assign out_valid = w_v_ff;
   assign out_last  = w_last_ff;
   assign out_addr  = w_addr_ff;
   assign out_word  = w_word_ff;

endmodule
`default_nettype wire

// ===== sv/gas_diffusion_grid_step_core.sv =====
// Gas diffusion grid step core: top level with command sequencer and two RAM banks.
// Depends on gds_pkg, gds_ram and gds_stencil.
// A step streams each cell through the stencil window over the single read port.
// One transaction at a time; busy stays high until its result strobe, but an ignored command
// is answered without raising busy. Results cannot stall.
// After reset a clearing pass over all GRID_SIZE*GRID_SIZE cells runs with busy high.
`default_nettype none
module gas_diffusion_grid_step_core #(
   parameter int GRID_SIZE = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire gds_pkg::req_type req_data,
   output logic                 rsp_valid,
   output gds_pkg::rsp_type     rsp_data
);

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int FEED  = CELLS + GRID_SIZE;
   localparam int FW    = $clog2(FEED + 1);
   localparam int WW    = $bits(gds_pkg::cell_word_type);

   gds_pkg::state_type state_ff, state_in;
   logic               cur_ff, cur_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [FW-1:0]      fcnt_ff, fcnt_in;
   logic               feed_v_ff, feed_v_in;
   logic               feed_pad_ff, feed_pad_in;
   logic [2:0]         cmd_kind_ff, cmd_kind_in;
   logic [31:0]        cmd_amt_ff, cmd_amt_in;
   logic [AW-1:0]      cmd_addr_ff, cmd_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gds_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   in_grid;
   logic [AW-1:0]          req_addr;
   logic                   sweep_start;
   logic [AW-1:0]          rd_addr;
   gds_pkg::cell_word_type rd0, rd1, rdata;
   logic                   we;
   logic                   wbank;
   logic [AW-1:0]          waddr;
   gds_pkg::cell_word_type wdata;
   gds_pkg::cell_word_type cmd_word;
   logic                   cmd_sat;
   logic [32:0]            sum;

   logic                   st_valid;
   logic                   st_last;
   logic [AW-1:0]          st_addr;
   gds_pkg::cell_word_type st_word;

   assign busy   = (state_ff != gds_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign in_grid = (req_data.col >= 0) && (req_data.row >= 0)
                && (int'(req_data.col) < GRID_SIZE) && (int'(req_data.row) < GRID_SIZE);
   assign req_addr = AW'(req_data.row[6:0]) * AW'(GRID_SIZE) + AW'(req_data.col[6:0]);
   assign rd_addr  = (state_ff == gds_pkg::ST_STEP) ? fcnt_ff[AW-1:0] : req_addr;
   assign rdata    = cur_ff ? rd1 : rd0;

   // Read-modify-write of one cell for the cell commands.
   always_comb begin
      cmd_word = rdata;
      cmd_sat  = 1'b0;
      sum      = {1'b0, rdata.pressure} + {1'b0, cmd_amt_ff};
      case (cmd_kind_ff)
         gds_pkg::KIND_ADD_WALL: cmd_word.wall = 1'b1;
         gds_pkg::KIND_DEL_WALL: cmd_word.wall = 1'b0;
         gds_pkg::KIND_ADD_PRESS: begin
            cmd_sat           = sum[32];
            cmd_word.pressure = sum[32] ? gds_pkg::PRESSURE_MAX : sum[31:0];
         end
         gds_pkg::KIND_SUB_PRESS: begin
            cmd_word.pressure = (rdata.pressure > cmd_amt_ff)
                              ? rdata.pressure - cmd_amt_ff : 32'd0;
         end
         default: cmd_word = rdata;
      endcase
   end

   always_comb begin
      we    = 1'b0;
      wbank = cur_ff;
      waddr = cmd_addr_ff;
      wdata = cmd_word;
      case (state_ff)
         gds_pkg::ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         gds_pkg::ST_CMD: we = 1'b1;
         gds_pkg::ST_STEP: begin
            // The step result goes to the other bank, which becomes current at the end.
            we    = st_valid;
            wbank = !cur_ff;
            waddr = st_addr;
            wdata = st_word;
         end
         default: we = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      fcnt_in      = fcnt_ff;
      feed_v_in    = 1'b0;
      feed_pad_in  = (fcnt_ff >= FW'(CELLS));
      cmd_kind_in  = cmd_kind_ff;
      cmd_amt_in   = cmd_amt_ff;
      cmd_addr_in  = cmd_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      sweep_start  = 1'b0;
      case (state_ff)
         gds_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in             = gds_pkg::ST_IDLE;
               rsp_valid_in         = clr_rsp_ff;
               rsp_data_in.in_range = 1'b1;
            end
         end
         gds_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_kind_in = req_data.kind;
               cmd_amt_in  = req_data.amount;
               cmd_addr_in = req_addr;
               case (req_data.kind)
                  gds_pkg::KIND_STEP: begin
                     state_in    = gds_pkg::ST_STEP;
                     fcnt_in     = '0;
                     sweep_start = 1'b1;
                  end
                  gds_pkg::KIND_CLEAR: begin
                     state_in   = gds_pkg::ST_CLEAR;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                  end
                  gds_pkg::KIND_ADD_WALL, gds_pkg::KIND_DEL_WALL, gds_pkg::KIND_ADD_PRESS,
                  gds_pkg::KIND_SUB_PRESS, gds_pkg::KIND_READ: begin
                     if (in_grid) begin
                        state_in = gds_pkg::ST_CMD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         gds_pkg::ST_CMD: begin
            state_in              = gds_pkg::ST_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_data_in.pressure  = cmd_word.pressure;
            rsp_data_in.wall      = cmd_word.wall;
            rsp_data_in.in_range  = 1'b1;
            rsp_data_in.saturated = cmd_sat;
         end
         gds_pkg::ST_STEP: begin
            if (fcnt_ff < FW'(FEED)) begin
               feed_v_in = 1'b1;
               fcnt_in   = fcnt_ff + 1'b1;
            end
            if (st_valid && st_last) begin
               state_in             = gds_pkg::ST_IDLE;
               cur_in               = !cur_ff;
               rsp_valid_in         = 1'b1;
               rsp_data_in.in_range = 1'b1;
            end
         end
         default: state_in = gds_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gds_pkg::ST_CLEAR;
         cur_ff       <= 1'b0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         fcnt_ff      <= '0;
         feed_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         fcnt_ff      <= fcnt_in;
         feed_v_ff    <= feed_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feed_pad_ff <= feed_pad_in;
      cmd_kind_ff <= cmd_kind_in;
      cmd_amt_ff  <= cmd_amt_in;
      cmd_addr_ff <= cmd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gds_ram #(
      .WIDTH(WW),
      .DEPTH(CELLS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (we && !wbank),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   gds_ram #(
      .WIDTH(WW),
      .DEPTH(CELLS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (we && wbank),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   gds_stencil #(
      .GRID_SIZE(GRID_SIZE)
   ) u_stencil (
      .clock       (clock),
      .reset       (reset),
      .sweep_start (sweep_start),
      .in_valid    (feed_v_ff),
      .in_pad      (feed_pad_ff),
      .in_word     (rdata),
      .out_valid   (st_valid),
      .out_last    (st_last),
      .out_addr    (st_addr),
      .out_word    (st_word)
   );

endmodule
`default_nettype wire
